>>> hw/rtl/column_projection_histogram_binned_unit_macros.svh
// Assertion macros for the column projection histogram unit.
// Taken in by the top level; no other dependencies.
`ifndef COLUMN_PROJECTION_HISTOGRAM_BINNED_UNIT_MACROS_SVH
`define COLUMN_PROJECTION_HISTOGRAM_BINNED_UNIT_MACROS_SVH

// same-cycle implication
`define CPHB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CPHB_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/cphb_pkg.sv
// Shared types and constants of the column projection histogram unit.
// No dependencies.
package cphb_pkg;

   localparam int DEF_MAX_BINS    = 64;
   localparam int DEF_MAX_COLUMNS = 2048;

   localparam int PIX_W     = 8;
   localparam int CFG_COL_W = 12;
   localparam int CFG_BIN_W = 7;
   localparam int COL_POS_W = 11;
   localparam int BIN_IDX_W = 6;
   localparam int COUNT_W   = 23;
   localparam int NUM_W     = COL_POS_W + CFG_BIN_W;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = CFG_COL_W;

   localparam logic [PIX_W-1:0]   EDGE_VALUE = 8'hFF;
   localparam logic [COUNT_W-1:0] COUNT_MAX  = 23'h7FFFFF;

   localparam logic [CFG_COL_W-1:0] RST_NUM_COLUMNS = 12'd640;
   localparam logic [CFG_BIN_W-1:0] RST_NUM_BINS    = 7'd64;

   localparam logic [CSR_IDX_W-1:0] REG_NUM_COLUMNS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NUM_BINS    = 1'd1;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_value;
      logic             frame_end;
   } req_type;

   typedef struct packed {
      logic [BIN_IDX_W-1:0] bin_index;
      logic [COUNT_W-1:0]   bin_count;
      logic                 last_bin;
   } rsp_type;

   typedef struct packed {
      logic                 done;
      logic [BIN_IDX_W-1:0] quot;
   } div_res_type;

endpackage

>>> hw/rtl/cphb_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cphb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/cphb_bin_div.sv
// Restoring divider for the bin index: one quotient bit per cycle.
// Depends on cphb_pkg.
module cphb_bin_div
   import cphb_pkg::*;
#(
   parameter int QUOT_W = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_W-1:0]     num,
   input  logic [CFG_COL_W-1:0] den,
   output div_res_type          res
);

   localparam int DW    = CFG_COL_W + QUOT_W;
   localparam int CMP_W = (NUM_W > DW) ? NUM_W : DW;
   localparam int CNT_W = (QUOT_W > 1) ? $clog2(QUOT_W) : 1;

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [NUM_W-1:0]  rem_ff, rem_in;
   logic [DW-1:0]     den_ff, den_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic              ge;

   assign ge = CMP_W'(rem_ff) >= CMP_W'(den_ff);

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      if (start) begin
         run_in  = 1'b1;
         cnt_in  = CNT_W'(QUOT_W - 1);
         rem_in  = num;
         den_in  = DW'(den) << (QUOT_W - 1);
         quot_in = '0;
      end else if (run_ff) begin
         if (ge) begin
            rem_in = NUM_W'(CMP_W'(rem_ff) - CMP_W'(den_ff));
         end
         quot_in = QUOT_W'({quot_ff, ge});
         den_in  = den_ff >> 1;
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign res.done = done_ff;
   assign res.quot = BIN_IDX_W'(quot_ff);

endmodule

>>> hw/rtl/column_projection_histogram_binned_unit.sv
// Top level of the column projection histogram unit: control, config, column tracking.
// Depends on cphb_pkg, cphb_ram, cphb_bin_div and the macros header.
//
//   channel  ports                       handshake
//   req      start, busy, req_data       beat taken when start && !busy
//   rsp      rsp_strobe, rsp_data        one cycle per beat, never stalled
//   csr      csr_we, csr_index, csr_wdata  written when csr_we
//
// A pixel other than 255 only steps the column; a 255 pixel also runs the bit-serial
// bin divider, followed by the counter read and write-back.
// Frame end then runs one sweep over the counter RAM that zeroes each entry and reports
// those below the bin count; rsp beats are registered, so the last can appear as busy drops.
// After reset the same sweep clears the RAM silently.
`include "column_projection_histogram_binned_unit_macros.svh"

module column_projection_histogram_binned_unit
   import cphb_pkg::*;
#(
   parameter int MAX_BINS    = DEF_MAX_BINS,
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_strobe,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int BIN_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int SC_W  = BIN_W + 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DIV   = 3'd1;
   localparam logic [2:0] S_WRITE = 3'd2;
   localparam logic [2:0] S_SWEEP = 3'd3;

   logic [2:0]           state_ff, state_in;
   logic [CFG_COL_W-1:0] ncol_ff, ncol_in;
   logic [CFG_BIN_W-1:0] nbin_ff, nbin_in;
   logic [COL_POS_W-1:0] pos_ff, pos_in;
   logic                 fend_ff, fend_in;
   logic                 emit_ff, emit_in;
   logic [BIN_W-1:0]     bin_ff, bin_in;
   logic [SC_W-1:0]      sc_ff, sc_in;
   logic                 pend_ff, pend_in;
   logic [BIN_W-1:0]     paddr_ff, paddr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic [CFG_COL_W-1:0] eff_nc;
   logic [CFG_BIN_W-1:0] eff_nb;
   logic [COL_POS_W-1:0] col;
   logic [CFG_COL_W-1:0] col_next;
   logic                 accept;
   logic                 is_edge;
   logic [NUM_W-1:0]     prod;
   div_res_type          div_res;

   logic                 ram_we;
   logic [BIN_W-1:0]     ram_waddr;
   logic [COUNT_W-1:0]   ram_wdata;
   logic [BIN_W-1:0]     ram_raddr;
   logic [COUNT_W-1:0]   ram_rdata;

   always_comb begin
      eff_nc = ncol_ff;
      if (ncol_ff == '0) begin
         eff_nc = CFG_COL_W'(1);
      end else if ({1'b0, ncol_ff} > (CFG_COL_W + 1)'(MAX_COLUMNS)) begin
         eff_nc = CFG_COL_W'(MAX_COLUMNS);
      end
      eff_nb = nbin_ff;
      if (nbin_ff == '0) begin
         eff_nb = CFG_BIN_W'(1);
      end else if ({1'b0, nbin_ff} > (CFG_BIN_W + 1)'(MAX_BINS)) begin
         eff_nb = CFG_BIN_W'(MAX_BINS);
      end
   end

   assign busy     = state_ff != S_IDLE;
   assign accept   = start && !busy;
   assign is_edge  = req_data.pixel_value == EDGE_VALUE;
   assign col      = (CFG_COL_W'(pos_ff) >= eff_nc) ? '0 : pos_ff;
   assign col_next = CFG_COL_W'(col) + 1'b1;
   assign prod     = NUM_W'(col) * NUM_W'(eff_nb);

   cphb_bin_div #(
      .QUOT_W (BIN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (accept && is_edge),
      .num   (prod),
      .den   (eff_nc),
      .res   (div_res)
   );

   cphb_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (MAX_BINS)
   ) u_bins (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      ram_raddr = (state_ff == S_DIV) ? BIN_W'(div_res.quot) : sc_ff[BIN_W-1:0];
      ram_we    = (state_ff == S_WRITE) || pend_ff;
      ram_waddr = (state_ff == S_WRITE) ? bin_ff : paddr_ff;
      ram_wdata = '0;
      if (state_ff == S_WRITE) begin
         ram_wdata = (ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + 1'b1;
      end
   end

   always_comb begin
      ncol_in  = ncol_ff;
      nbin_in  = nbin_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_NUM_COLUMNS: ncol_in = csr_wdata[CFG_COL_W-1:0];
            REG_NUM_BINS:    nbin_in = csr_wdata[CFG_BIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      fend_in  = fend_ff;
      emit_in  = emit_ff;
      bin_in   = bin_ff;
      sc_in    = sc_ff;
      pend_in  = 1'b0;
      paddr_in = sc_ff[BIN_W-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               fend_in = req_data.frame_end;
               if (req_data.frame_end) begin
                  pos_in = '0;
               end else if (col_next >= eff_nc) begin
                  pos_in = '0;
               end else begin
                  pos_in = col_next[COL_POS_W-1:0];
               end
               if (is_edge) begin
                  state_in = S_DIV;
               end else if (req_data.frame_end) begin
                  state_in = S_SWEEP;
                  emit_in  = 1'b1;
                  sc_in    = '0;
               end
            end
         end
         S_DIV: begin
            if (div_res.done) begin
               bin_in   = BIN_W'(div_res.quot);
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            if (fend_ff) begin
               state_in = S_SWEEP;
               emit_in  = 1'b1;
               sc_in    = '0;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SWEEP: begin
            if (sc_ff == SC_W'(MAX_BINS)) begin
               state_in = S_IDLE;
            end else begin
               pend_in = 1'b1;
               sc_in   = sc_ff + 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in     = pend_ff && emit_ff && (CFG_BIN_W'(paddr_ff) < eff_nb);
      rsp_in.bin_index = BIN_IDX_W'(paddr_ff);
      rsp_in.bin_count = ram_rdata;
      rsp_in.last_bin  = CFG_BIN_W'(paddr_ff) == (eff_nb - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         ncol_ff      <= RST_NUM_COLUMNS;
         nbin_ff      <= RST_NUM_BINS;
         pos_ff       <= '0;
         fend_ff      <= 1'b0;
         emit_ff      <= 1'b0;
         sc_ff        <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ncol_ff      <= ncol_in;
         nbin_ff      <= nbin_in;
         pos_ff       <= pos_in;
         fend_ff      <= fend_in;
         emit_ff      <= emit_in;
         sc_ff        <= sc_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bin_ff   <= bin_in;
      paddr_ff <= paddr_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   `CPHB_ASSERT_IMP(a_div_done_in_div, clock, reset, div_res.done, state_ff == S_DIV, "divider done outside of divide state")
   `CPHB_ASSERT_NXT(a_edge_starts_div, clock, reset, accept && is_edge, state_ff == S_DIV, "edge pixel did not start the divider")
   `CPHB_ASSERT_IMP(a_rsp_from_sweep, clock, reset, rsp_strobe, $past(pend_ff) && $past(emit_ff), "rsp beat without a reporting sweep")
   `CPHB_ASSERT_IMP(a_single_writer, clock, reset, state_ff == S_WRITE, !pend_ff, "counter update collides with sweep clear")

endmodule
